// ===== rtl/core/pcc_pkg.sv =====
package pcc_pkg;

    // Palette geometry.
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int PAL_W       = 24;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_DEPTH   = 1'b1;

    // Item operations.
    localparam logic OP_CONVERT   = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    typedef enum logic [1:0] {
        SRC_YUV88   = 2'd0,
        SRC_YUV1616 = 2'd1,
        SRC_RGB     = 2'd2,
        SRC_PALETTE = 2'd3
    } t_src_mode;

    typedef enum logic [1:0] {
        DEPTH_555 = 2'd0,
        DEPTH_565 = 2'd1,
        DEPTH_24  = 2'd2,
        DEPTH_32  = 2'd3
    } t_depth;

    // Signed widths of the YUV datapath.
    localparam int CHROMA_W = 9;
    localparam int COEF_W   = 18;
    localparam int SUM_W    = 27;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // 8.8 coefficients.
    localparam t_coef C88_B_U = 18'sd454;
    localparam t_coef C88_G_U = -18'sd88;
    localparam t_coef C88_G_V = -18'sd183;
    localparam t_coef C88_R_V = 18'sd359;

    // 16.16 coefficients, with U and V in the standard assignment.
    localparam t_coef C1616_B_U = 18'sd116129;
    localparam t_coef C1616_G_U = -18'sd22553;
    localparam t_coef C1616_G_V = -18'sd46801;
    localparam t_coef C1616_R_V = 18'sd91881;

    localparam logic signed [CHROMA_W-1:0] CHROMA_OFFSET = 9'sd128;

    localparam t_sum HI_88   = 27'sh000ffff;
    localparam t_sum LO_88   = 27'sh00000ff;
    localparam t_sum HI_1616 = 27'sh0ffffff;
    localparam t_sum LO_1616 = 27'sh000ffff;

    // Saturates one channel sum to 0..255 at the selected fixed-point scale.
    function automatic logic [7:0] clamp_chan(input t_sum sum, input logic wide);
        logic [7:0] res;
        if (wide) begin
            if (sum > HI_1616) begin
                res = 8'hff;
            end else if (sum <= LO_1616) begin
                res = 8'h00;
            end else begin
                res = sum[23:16];
            end
        end else begin
            if (sum > HI_88) begin
                res = 8'hff;
            end else if (sum <= LO_88) begin
                res = 8'h00;
            end else begin
                res = sum[15:8];
            end
        end
        return res;
    endfunction

    // Packs a color into the display format; unused high bits are zero.
    function automatic logic [31:0] pack_pixel(
        input t_depth     depth,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b,
        input logic [7:0] top
    );
        logic [31:0] res;
        unique case (depth)
            DEPTH_555: res = {17'd0, r[7:3], g[7:3], b[7:3]};
            DEPTH_565: res = {16'd0, r[7:3], g[7:2], b[7:3]};
            DEPTH_24:  res = {8'd0, r, g, b};
            DEPTH_32:  res = {top, r, g, b};
            default:   res = {top, r, g, b};
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/pcc_ram.sv =====
module pcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pixel_color_converter.sv =====
// Pixel color converter: one source pixel in, one packed display pixel out.
// Input channel (i_in_valid / o_in_ready) carries one item per transfer:
// a convert item (i_op = 0) yields exactly one pixel on the output channel
// (o_out_valid / i_out_ready); a palette write item (i_op = 1) stores
// {chan_a, chan_b, chan_c} at i_entry and yields nothing.
// The source format and output depth come from two registers on the plain
// write port (i_cfg_we, i_cfg_index, i_cfg_data); the user must write them
// only while idle, as the block itself does not enforce this. Throughput is
// one item per clock unless the receiver stalls; there are three pipeline
// stages (palette read, chroma multiply, sum, clamp and pack).
// When the receiver stalls, the whole pipeline holds and o_in_ready stays
// low for as long as a finished pixel waits at the output.
// Synchronous reset empties the pipeline and selects YUV 8.8 source at
// 32-bit depth. Palette contents are undefined until written, and a palette
// write is visible to the very next convert item.
module pixel_color_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [7:0]                       i_chan_a,
    input  logic [7:0]                       i_chan_b,
    input  logic [7:0]                       i_chan_c,
    input  logic [7:0]                       i_spare_byte,
    input  logic [7:0]                       i_entry,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [31:0]                      o_pixel
);

    pcc_pkg::t_src_mode r_source_mode;
    pcc_pkg::t_depth    r_out_depth;

    logic en;
    logic in_xfer;
    logic pal_we;

    // Stage 1: captured item, palette read in flight.
    logic       r1_valid;
    logic [7:0] r1_a, r1_b, r1_c, r1_spare;
    logic       r1_pal_ok;
    logic [pcc_pkg::PAL_W-1:0] pal_rdata;

    // Stage 2: chroma products.
    logic          r2_valid;
    pcc_pkg::t_sum r2_s, r2_pb, r2_pgu, r2_pgv, r2_pr;
    logic [23:0]   r2_rgb;
    logic [7:0]    r2_top;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_pixel;

    logic signed [pcc_pkg::CHROMA_W-1:0] u, v;
    pcc_pkg::t_coef cb_u, cg_u, cg_v, cr_v;
    logic           yuv_mode, wide_mode;
    logic [23:0]    n_rgb;
    logic [7:0]     n_top;

    logic [7:0]  ch_r, ch_g, ch_b;
    logic [31:0] n_pixel;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign in_xfer    = i_in_valid && en;
    assign pal_we     = in_xfer && (i_op == pcc_pkg::OP_PAL_WRITE)
                        && (32'(i_entry) < pcc_pkg::PAL_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_mode <= pcc_pkg::SRC_YUV88;
            r_out_depth   <= pcc_pkg::DEPTH_32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcc_pkg::CFG_SOURCE_MODE: r_source_mode <= pcc_pkg::t_src_mode'(i_cfg_data);
                pcc_pkg::CFG_OUT_DEPTH:   r_out_depth   <= pcc_pkg::t_depth'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Palette writes land at the transfer edge, so a convert item that
    // follows reads the new entry with no forwarding needed.
    pcc_ram #(
        .WIDTH (pcc_pkg::PAL_W),
        .DEPTH (pcc_pkg::PAL_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_entry[pcc_pkg::PAL_AW-1:0]),
        .i_wdata ({i_chan_a, i_chan_b, i_chan_c}),
        .i_re    (en),
        .i_raddr (i_chan_a[pcc_pkg::PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= in_xfer && (i_op == pcc_pkg::OP_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a      <= i_chan_a;
            r1_b      <= i_chan_b;
            r1_c      <= i_chan_c;
            r1_spare  <= i_spare_byte;
            r1_pal_ok <= 32'(i_chan_a) < pcc_pkg::PAL_ENTRIES;
        end
    end

    // Stage 1 logic: coefficient selection and products.
    assign wide_mode = (r_source_mode == pcc_pkg::SRC_YUV1616);
    assign u = $signed({1'b0, r1_b}) - pcc_pkg::CHROMA_OFFSET;
    assign v = $signed({1'b0, r1_c}) - pcc_pkg::CHROMA_OFFSET;

    always_comb begin
        if (wide_mode) begin
            cb_u = pcc_pkg::C1616_B_U;
            cg_u = pcc_pkg::C1616_G_U;
            cg_v = pcc_pkg::C1616_G_V;
            cr_v = pcc_pkg::C1616_R_V;
        end else begin
            cb_u = pcc_pkg::C88_B_U;
            cg_u = pcc_pkg::C88_G_U;
            cg_v = pcc_pkg::C88_G_V;
            cr_v = pcc_pkg::C88_R_V;
        end
    end

    always_comb begin
        case (r_source_mode)
            pcc_pkg::SRC_RGB: begin
                n_rgb = {r1_a, r1_b, r1_c};
                n_top = r1_spare;
            end
            pcc_pkg::SRC_PALETTE: begin
                n_rgb = r1_pal_ok ? pal_rdata : 24'd0;
                n_top = 8'd0;
            end
            default: begin
                n_rgb = 24'd0;
                n_top = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    // Both factors are sign-extended to the sum width so that the full
    // product is kept.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_s   <= wide_mode ? $signed({3'd0, r1_a, 16'd0})
                                : $signed({11'd0, r1_a, 8'd0});
            r2_pb  <= pcc_pkg::t_sum'(u) * pcc_pkg::t_sum'(cb_u);
            r2_pgu <= pcc_pkg::t_sum'(u) * pcc_pkg::t_sum'(cg_u);
            r2_pgv <= pcc_pkg::t_sum'(v) * pcc_pkg::t_sum'(cg_v);
            r2_pr  <= pcc_pkg::t_sum'(v) * pcc_pkg::t_sum'(cr_v);
            r2_rgb <= n_rgb;
            r2_top <= n_top;
        end
    end

    // Stage 2 logic: sums, saturation and packing.
    assign yuv_mode = (r_source_mode == pcc_pkg::SRC_YUV88) || wide_mode;

    always_comb begin
        if (yuv_mode) begin
            ch_r = pcc_pkg::clamp_chan(r2_s + r2_pr, wide_mode);
            ch_g = pcc_pkg::clamp_chan(r2_s + r2_pgu + r2_pgv, wide_mode);
            ch_b = pcc_pkg::clamp_chan(r2_s + r2_pb, wide_mode);
        end else begin
            ch_r = r2_rgb[23:16];
            ch_g = r2_rgb[15:8];
            ch_b = r2_rgb[7:0];
        end
        n_pixel = pcc_pkg::pack_pixel(r_out_depth, ch_r, ch_g, ch_b, r2_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pixel;

endmodule

// ===== dv/pcc_pixel_checker.sv =====
`timescale 1ns / 1ps
module pcc_pixel_checker
    import pcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_op,
    input  logic [7:0]            i_chan_a,
    input  logic [7:0]            i_chan_b,
    input  logic [7:0]            i_chan_c,
    input  logic [7:0]            i_spare_byte,
    input  logic [7:0]            i_entry,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [31:0]           i_pixel,
    output int                    o_pending,
    output int                    o_errors
);

    // BT.601 weights, chroma centered on zero.
    localparam int Q8_R_V    = 359;
    localparam int Q8_G_U    = 88;
    localparam int Q8_G_V    = 183;
    localparam int Q8_B_U    = 454;
    localparam int Q16_R_V   = 91881;
    localparam int Q16_G_U   = 22553;
    localparam int Q16_G_V   = 46801;
    localparam int Q16_B_U   = 116129;
    localparam int CHROMA_MID = 128;

    t_src_mode   source_mode;
    t_depth      out_depth;
    logic [23:0] shadow_palette [PAL_ENTRIES];
    logic [31:0] expected_pixels [$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    function automatic logic [7:0] sat_q8(input int sum);
        if (sum > 65535) return 8'hff;
        if (sum <= 255) return 8'h00;
        return sum[15:8];
    endfunction

    function automatic logic [7:0] sat_q16(input int sum);
        if (sum > 16777215) return 8'hff;
        if (sum <= 65535) return 8'h00;
        return sum[23:16];
    endfunction

    function automatic logic [31:0] convert_pixel(
        input t_src_mode   mode,
        input t_depth      depth,
        input logic [7:0]  ca,
        input logic [7:0]  cb,
        input logic [7:0]  cc,
        input logic [7:0]  spare,
        input logic [23:0] pal_color
    );
        int         luma;
        int         u;
        int         v;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] top;
        u   = int'(cb) - CHROMA_MID;
        v   = int'(cc) - CHROMA_MID;
        top = 8'h00;
        case (mode)
            SRC_YUV88: begin
                luma = int'(ca) * 256;
                r = sat_q8(luma + Q8_R_V * v);
                g = sat_q8(luma - Q8_G_U * u - Q8_G_V * v);
                b = sat_q8(luma + Q8_B_U * u);
            end
            SRC_YUV1616: begin
                luma = int'(ca) * 65536;
                r = sat_q16(luma + Q16_R_V * v);
                g = sat_q16(luma - Q16_G_U * u - Q16_G_V * v);
                b = sat_q16(luma + Q16_B_U * u);
            end
            SRC_RGB: begin
                r   = ca;
                g   = cb;
                b   = cc;
                top = spare;
            end
            default: begin
                {r, g, b} = pal_color;
            end
        endcase
        case (depth)
            DEPTH_555: return {17'd0, r[7:3], g[7:3], b[7:3]};
            DEPTH_565: return {16'd0, r[7:3], g[7:2], b[7:3]};
            DEPTH_24:  return {8'd0, r, g, b};
            default:   return {top, r, g, b};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t ns: %s, got %08h, expected %08h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin : track
        logic [31:0] want;
        logic [23:0] color;
        if (!i_rst_n) begin
            source_mode = SRC_YUV88;
            out_depth   = DEPTH_32;
            expected_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with nothing pending", i_pixel, 32'h0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel !== want) begin
                        report_mismatch("pixel", i_pixel, want);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SOURCE_MODE: source_mode = t_src_mode'(i_cfg_data);
                    CFG_OUT_DEPTH:   out_depth   = t_depth'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_PAL_WRITE) begin
                    if (int'(i_entry) < PAL_ENTRIES) begin
                        shadow_palette[i_entry] = {i_chan_a, i_chan_b, i_chan_c};
                    end
                end else begin
                    // An index past the end of the palette reads as black.
                    color = (int'(i_chan_a) < PAL_ENTRIES) ? shadow_palette[i_chan_a] : 24'h0;
                    expected_pixels.push_back(convert_pixel(source_mode, out_depth, i_chan_a,
                                                            i_chan_b, i_chan_c, i_spare_byte,
                                                            color));
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== dv/pixel_color_converter_tb.sv =====
`timescale 1ns / 1ps
module pixel_color_converter_tb;
    import pcc_pkg::*;

    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int ITEMS_PER_SETTING = 120;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  op          = OP_CONVERT;
    logic [7:0]            chan_a      = '0;
    logic [7:0]            chan_b      = '0;
    logic [7:0]            chan_c      = '0;
    logic [7:0]            spare_byte  = '0;
    logic [7:0]            entry       = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [31:0]           pixel;

    int        pending;
    int        errors;
    int        cycle_cnt     = 0;
    int        ready_hold    = 0;
    bit        in_gaps_on    = 1'b1;
    bit        out_stalls_on = 1'b1;
    t_src_mode cur_mode      = SRC_YUV88;
    bit        pal_written [PAL_ENTRIES];
    logic [7:0] written_entries [$];

    always #4 i_clk = ~i_clk;

    pixel_color_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_op         (op),
        .i_chan_a     (chan_a),
        .i_chan_b     (chan_b),
        .i_chan_c     (chan_c),
        .i_spare_byte (spare_byte),
        .i_entry      (entry),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_pixel      (pixel)
    );

    pcc_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_op         (op),
        .i_chan_a     (chan_a),
        .i_chan_b     (chan_b),
        .i_chan_c     (chan_c),
        .i_spare_byte (spare_byte),
        .i_entry      (entry),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_pixel      (pixel),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    // Receiver back-pressure: mostly ready, with short and occasional long stalls.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!out_stalls_on || $urandom_range(0, 99) < 70) begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            out_ready  <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!in_gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Channel values lean toward the points where clamping and offsets bite.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [7] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'h81, 8'hfe, 8'hff};
        if ($urandom_range(0, 99) < 25) return corners[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Valid stays high after a transfer until the next call either lowers it
    // for a gap or presents the next item.
    task automatic send_item(input logic it_op, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] spare,
                             input logic [7:0] addr);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        op         <= it_op;
        chan_a     <= a;
        chan_b     <= b;
        chan_c     <= c;
        spare_byte <= spare;
        entry      <= addr;
        if (it_op == OP_PAL_WRITE && !pal_written[addr]) begin
            pal_written[addr] = 1'b1;
            written_entries.push_back(addr);
        end
        do @(posedge i_clk); while (in_ready !== 1'b1);
    endtask

    // Palette writes leave nothing pending, so allow the pipeline to empty.
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_format(input t_src_mode mode, input t_depth depth);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE_MODE;
        cfg_data  <= mode;
        @(negedge i_clk);
        cfg_index <= CFG_OUT_DEPTH;
        cfg_data  <= depth;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic send_random_item();
        logic [7:0] a;
        bit         is_write;
        // Palette lookups only ever target entries that have been written.
        is_write = ($urandom_range(0, 99) < 15) ||
                   (cur_mode == SRC_PALETTE && written_entries.size() == 0);
        if (is_write) begin
            send_item(OP_PAL_WRITE, pick_byte(), pick_byte(), pick_byte(),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
            if (cur_mode == SRC_PALETTE) begin
                a = written_entries[$urandom_range(0, written_entries.size() - 1)];
            end else begin
                a = pick_byte();
            end
            send_item(OP_CONVERT, a, pick_byte(), pick_byte(),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset format is YUV 8.8 at 32 bits; the top byte must stay zero.
        send_item(OP_CONVERT, 8'h00, 8'h80, 8'h80, 8'h00, 8'h00);
        send_item(OP_CONVERT, 8'hff, 8'h80, 8'h80, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_CONVERT, 8'h80, 8'h00, 8'hff, 8'h5a, 8'h00);
        send_item(OP_CONVERT, 8'h80, 8'hff, 8'h00, 8'ha5, 8'h00);

        send_item(OP_PAL_WRITE, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00);
        send_item(OP_PAL_WRITE, 8'h12, 8'h34, 8'h56, 8'hff, 8'hff);
        send_item(OP_PAL_WRITE, 8'h00, 8'h00, 8'h00, 8'hff, 8'h80);
        send_item(OP_PAL_WRITE, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h7f);

        program_format(SRC_YUV1616, DEPTH_24);
        send_item(OP_CONVERT, 8'h00, 8'h80, 8'h80, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_CONVERT, 8'h10, 8'hff, 8'h00, 8'h00, 8'h00);

        program_format(SRC_RGB, DEPTH_32);
        send_item(OP_CONVERT, 8'hff, 8'h00, 8'hff, 8'ha5, 8'h00);
        send_item(OP_CONVERT, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00);

        program_format(SRC_RGB, DEPTH_555);
        send_item(OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'h08, 8'h04, 8'h08, 8'h00, 8'h00);

        program_format(SRC_RGB, DEPTH_565);
        send_item(OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'hf8, 8'hfc, 8'hf8, 8'h00, 8'h00);

        // Palette source ignores the spare byte, and a fresh write must be
        // visible to the convert right behind it.
        program_format(SRC_PALETTE, DEPTH_32);
        send_item(OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(OP_CONVERT, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_PAL_WRITE, 8'hde, 8'had, 8'hbe, 8'h00, 8'h01);
        send_item(OP_CONVERT, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);

        for (int setting = 0; setting < 16; setting++) begin
            program_format(t_src_mode'(setting[3:2]), t_depth'(setting[1:0]));
            in_gaps_on    = ($urandom_range(0, 3) != 0);
            out_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_SETTING) send_random_item();
        end

        settle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
